/* design/asbc_pkg.sv */
// ----------------------------------------------------------------------------
// asbc_pkg
// Shared types and constants for the audio stream buffer controller.
// ----------------------------------------------------------------------------
package asbc_pkg;

	// Default ring size in bytes
	localparam int unsigned BUFFER_BYTES_DEF = 65536;

	// Fixed field widths
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned REQ_W    = 16;
	localparam int unsigned COMMIT_W = 32;
	localparam int unsigned TOTAL_W  = 64;
	localparam int unsigned REG_W    = 32;
	localparam int unsigned IDX_W    = 2;

	// Prefill target rules
	localparam int unsigned DEFAULT_PERIOD = 4096;
	localparam int unsigned PREFILL_MIN    = 8192;

	// Command codes
	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_COMMIT  = 2'd1,
		CMD_READ    = 2'd2,
		CMD_CONSUME = 2'd3
	} cmd_t;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_SAMPLE_RATE   = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_PERIOD_BYTES  = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	// What a start command picks up from the register file
	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] target;
	} start_cfg_t;

endpackage

/* design/asbc_cfg.sv */
// ----------------------------------------------------------------------------
// asbc_cfg
// Configuration registers and the prefill target derived from them.
// ----------------------------------------------------------------------------
module asbc_cfg import asbc_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	output start_cfg_t       start_cfg
);

	localparam int unsigned TW = 19;
	localparam logic [TW-1:0] HALF_T    = TW'(BUFFER_BYTES / 2);
	localparam logic [TW-1:0] FULL_T    = TW'(BUFFER_BYTES);
	localparam logic [TW-1:0] MIN_T     = TW'(PREFILL_MIN);
	localparam logic [REQ_W-1:0] DEF_P  = REQ_W'(DEFAULT_PERIOD);

	logic [REG_W-1:0] sample_rate_q;
	logic [REG_W-1:0] channel_count_q;
	logic [REQ_W-1:0] period_bytes_q;
	logic [REQ_W-1:0] period;
	logic [TW-1:0]    t_x4;
	logic [TW-1:0]    t_lo;
	logic [TW-1:0]    t_half;
	logic [TW-1:0]    t_full;

	assign cfg_ready = 1'b1;

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q   <= '0;
			channel_count_q <= '0;
			period_bytes_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SAMPLE_RATE:   sample_rate_q   <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				REG_PERIOD_BYTES:  period_bytes_q  <= cfg_data[REQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Prefill target: four periods, at least the floor, at most half the ring
	always_comb begin
		period = (period_bytes_q == '0) ? DEF_P : period_bytes_q;
		t_x4   = {1'b0, period, 2'b00};
		t_lo   = (t_x4 < MIN_T) ? MIN_T : t_x4;
		t_half = (t_lo > HALF_T) ? HALF_T : t_lo;
		t_full = (t_half > FULL_T) ? FULL_T : t_half;
	end

	assign start_cfg.ok     = (sample_rate_q != '0) && (channel_count_q != '0);
	assign start_cfg.target = t_full[CNT_W-1:0];

endmodule

/* design/asbc_engine.sv */
// ----------------------------------------------------------------------------
// asbc_engine
// Input register, ring bookkeeping for one command, and result register.
// ----------------------------------------------------------------------------
module asbc_engine import asbc_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  start_cfg_t          start_cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [COMMIT_W-1:0] commit_bytes,
	input  logic [REQ_W-1:0]    request_bytes,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CNT_W-1:0]    byte_count,
	output logic                started,
	output logic [REQ_W-1:0]    read_start,
	output logic [REQ_W-1:0]    first_length,
	output logic [REQ_W-1:0]    second_length,
	output logic [REQ_W-1:0]    silence_bytes,
	output logic [TOTAL_W-1:0]  underrun_count,
	output logic [TOTAL_W-1:0]  underrun_bytes
);

	localparam int unsigned POS_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);

	// Input stage
	logic                s1_valid_q;
	cmd_t                cmd_s1;
	logic [COMMIT_W-1:0] commit_s1;
	logic [REQ_W-1:0]    req_s1;

	// Ring state
	logic [POS_W-1:0]    rp_q;
	logic [CNT_W-1:0]    queued_q;
	logic                pending_q;
	logic [CNT_W-1:0]    target_q;
	logic                running_q;
	logic [TOTAL_W-1:0]  ev_total_q;
	logic [TOTAL_W-1:0]  by_total_q;

	// Next state and result
	logic [POS_W-1:0]    rp_d;
	logic [CNT_W-1:0]    queued_d;
	logic                pending_d;
	logic [CNT_W-1:0]    target_d;
	logic                running_d;
	logic [TOTAL_W-1:0]  ev_total_d;
	logic [TOTAL_W-1:0]  by_total_d;
	logic [REQ_W-1:0]    rstart_d;
	logic [REQ_W-1:0]    first_d;
	logic [REQ_W-1:0]    second_d;
	logic [REQ_W-1:0]    silence_d;

	// Step temporaries
	logic [CNT_W-1:0]    room;
	logic [CNT_W-1:0]    add;
	logic [CNT_W-1:0]    req_ext;
	logic [CNT_W-1:0]    nread;
	logic [CNT_W-1:0]    to_end;
	logic [CNT_W-1:0]    first_c;
	logic [CNT_W-1:0]    pos_sum;
	logic [CNT_W-1:0]    pos_wrap;
	logic [CNT_W-1:0]    short_c;

	logic s2_ready;
	logic advance;
	logic accept;

	// Handshake: result register frees when taken, input stage drains into it
	assign s2_ready = !out_valid || !out_stall;
	assign advance  = s1_valid_q && s2_ready;
	assign in_stall = s1_valid_q && !s2_ready;
	assign accept   = in_valid && !in_stall;

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_t'(cmd);
			commit_s1 <= commit_bytes;
			req_s1    <= request_bytes;
		end
	end

	// Shared datapath terms
	always_comb begin
		room     = BUF_CNT - queued_q;
		add      = (commit_s1 < COMMIT_W'(room)) ? commit_s1[CNT_W-1:0] : room;
		req_ext  = CNT_W'(req_s1);
		nread    = (queued_q < req_ext) ? queued_q : req_ext;
		to_end   = BUF_CNT - CNT_W'(rp_q);
		first_c  = (nread < to_end) ? nread : to_end;
		pos_sum  = CNT_W'(rp_q) + nread;
		pos_wrap = (pos_sum >= BUF_CNT) ? (pos_sum - BUF_CNT) : pos_sum;
		short_c  = req_ext - nread;
	end

	// Apply one command
	always_comb begin
		rp_d       = rp_q;
		queued_d   = queued_q;
		pending_d  = pending_q;
		target_d   = target_q;
		running_d  = running_q;
		ev_total_d = ev_total_q;
		by_total_d = by_total_q;
		rstart_d   = '0;
		first_d    = '0;
		second_d   = '0;
		silence_d  = '0;
		unique case (cmd_s1)
			CMD_START: begin
				rp_d      = '0;
				queued_d  = '0;
				pending_d = 1'b1;
				running_d = start_cfg.ok;
				if (start_cfg.ok) begin
					target_d   = start_cfg.target;
					ev_total_d = '0;
					by_total_d = '0;
				end
			end
			CMD_COMMIT: begin
				if (running_q) begin
					queued_d = queued_q + add;
				end
			end
			CMD_READ: ;
			CMD_CONSUME: begin
				if (req_s1 != '0) begin
					if (!running_q) begin
						silence_d = req_s1;
					end else if (pending_q && (queued_q < target_q)) begin
						// Still prefilling: deliver nothing
						rstart_d  = REQ_W'(rp_q);
						silence_d = req_s1;
					end else begin
						rstart_d  = REQ_W'(rp_q);
						first_d   = first_c[REQ_W-1:0];
						second_d  = REQ_W'(nread - first_c);
						rp_d      = pos_wrap[POS_W-1:0];
						queued_d  = queued_q - nread;
						pending_d = 1'b0;
						// Short read: count the gap and rearm prefill
						if (short_c != '0) begin
							silence_d  = short_c[REQ_W-1:0];
							ev_total_d = ev_total_q + TOTAL_W'(1);
							by_total_d = by_total_q + TOTAL_W'(short_c);
							pending_d  = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Commit state as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			queued_q   <= '0;
			pending_q  <= 1'b1;
			target_q   <= '0;
			running_q  <= 1'b0;
			ev_total_q <= '0;
			by_total_q <= '0;
		end else if (advance) begin
			rp_q       <= rp_d;
			queued_q   <= queued_d;
			pending_q  <= pending_d;
			target_q   <= target_d;
			running_q  <= running_d;
			ev_total_q <= ev_total_d;
			by_total_q <= by_total_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_count     <= running_d ? queued_d : '0;
			started        <= running_d;
			read_start     <= rstart_d;
			first_length   <= first_d;
			second_length  <= second_d;
			silence_bytes  <= silence_d;
			underrun_count <= ev_total_d;
			underrun_bytes <= by_total_d;
		end
	end

	// Queue never holds more than the ring
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queued_q <= BUF_CNT)
		else $error("queued bytes exceed ring size");

	// Read position stays inside the ring
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(rp_q) < BUF_CNT)
		else $error("read position outside ring");

	// A stopped stream holds nothing
	a_stopped_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (queued_q == '0 && rp_q == '0))
		else $error("stopped stream holds data");

	// A delivered result reports an empty queue when stopped
	a_result_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !started) |-> (byte_count == '0 && first_length == '0))
		else $error("stopped result reports data");

	// The input stage only stalls while the result register is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && s1_valid_q))
		else $error("input stalled without a held result");

endmodule

/* design/audio_stream_buffer_controller_core.sv */
// ----------------------------------------------------------------------------
// audio_stream_buffer_controller_core
// Bookkeeping for an audio byte ring buffer with prefill before playback.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per beat: start,
//   commit bytes, read count or consume request. Every command yields one
//   result beat on the output channel (out_valid/out_stall) with the queued
//   byte count, the running flag, the read segments, the silence fill and
//   the underrun totals.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sample
//   rate, channel count and period size; write only while the block is idle.
//   cfg_ready is always high.
//   A command accepted into the input stage moves on to the result register.
//   Throughput: one command per cycle while the output is not stalled, set
//   by the single input stage feeding the result register.
//   Reset clears the control and ring state registers: the stream is
//   stopped, the queue is empty and the prefill wait is armed. No clearing
//   pass is needed.
//   When the receiver stalls, the result beat holds; one more command can
//   wait in the input stage, after which in_stall rises.
// ----------------------------------------------------------------------------
module audio_stream_buffer_controller_core import asbc_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [COMMIT_W-1:0] commit_bytes,
	input  logic [REQ_W-1:0]    request_bytes,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CNT_W-1:0]    byte_count,
	output logic                started,
	output logic [REQ_W-1:0]    read_start,
	output logic [REQ_W-1:0]    first_length,
	output logic [REQ_W-1:0]    second_length,
	output logic [REQ_W-1:0]    silence_bytes,
	output logic [TOTAL_W-1:0]  underrun_count,
	output logic [TOTAL_W-1:0]  underrun_bytes
);

	start_cfg_t start_cfg;

	// Register file and prefill target
	asbc_cfg #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start_cfg (start_cfg)
	);

	// Command pipeline
	asbc_engine #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.start_cfg      (start_cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.commit_bytes   (commit_bytes),
		.request_bytes  (request_bytes),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_count     (byte_count),
		.started        (started),
		.read_start     (read_start),
		.first_length   (first_length),
		.second_length  (second_length),
		.silence_bytes  (silence_bytes),
		.underrun_count (underrun_count),
		.underrun_bytes (underrun_bytes)
	);

endmodule
